// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the traffic monitor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/trm_pkg.sv
// Shared constants, types and codes of the traffic rate and activity monitor.
package trm_pkg;

   // Field widths.
   localparam int TOTAL_W = 64;
   localparam int DELTA_W = 31;
   localparam int HOURS_W = 21;
   localparam int MIN_W   = 6;
   localparam int TICKS_W = 32;
   localparam int MODE_W  = 2;
   localparam int STAT_W  = 2;

   // Averaging window, including the newest sample.
   localparam int WINDOW_DEPTH = 3;
   localparam int HIST_DEPTH   = WINDOW_DEPTH - 1;
   localparam int CNT_W        = $clog2(WINDOW_DEPTH);
   localparam int SUM_W        = DELTA_W + CNT_W;

   // Division of the window sum by a reciprocal multiplication.
   localparam int RECIP_SHIFT = SUM_W + CNT_W + 1;
   localparam int RECIP_W     = RECIP_SHIFT - CNT_W + 1;
   localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(
      ((64'd1 << RECIP_SHIFT) + 64'(WINDOW_DEPTH - 1)) / 64'(WINDOW_DEPTH));
   localparam int LO_W    = SUM_W / 2;
   localparam int HI_W    = SUM_W - LO_W;
   localparam int PLO_W   = LO_W + RECIP_W;
   localparam int PHI_W   = HI_W + RECIP_W;
   localparam int PROD_W  = SUM_W + RECIP_W;

   // Saturation value of a per-tick delta.
   localparam logic [DELTA_W-1:0] DELTA_MAX = '1;

   // Idle clock limits.
   localparam int SECS_PER_MIN  = 60;
   localparam int MINS_PER_HOUR = 60;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 31;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_THR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOT_THR  = 1'd1;
   localparam logic [DELTA_W-1:0] HOT_THR_RESET = 31'd10000;

   // Display modes.
   localparam logic [MODE_W-1:0] MODE_RATES   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_OFFLINE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

   // Activity status codes.
   localparam logic [STAT_W-1:0] STAT_IDLE      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_DOWNLOAD  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_UPLOAD    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_UNCHANGED = 2'd3;

   // Stream word widths.
   localparam int REQ_DATA_W   = 2 * TOTAL_W;
   localparam int RSP_FIELDS_W = 2 * DELTA_W + HOURS_W + 2 * MIN_W + STAT_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   // Load enables of the delta stages.
   typedef struct packed {
      logic load_in;
      logic load_delta;
   } delta_en_type;

   // Load enables of the averaging stages.
   typedef struct packed {
      logic load_sum;
      logic load_prod;
      logic load_avg;
   } avg_en_type;

   // One result word.
   typedef struct packed {
      logic [MODE_W-1:0]  display_mode;
      logic [DELTA_W-1:0] avg_rx;
      logic [DELTA_W-1:0] avg_tx;
      logic [HOURS_W-1:0] idle_hours;
      logic [MIN_W-1:0]   idle_minutes;
      logic [MIN_W-1:0]   idle_secs_part;
      logic [STAT_W-1:0]  activity_status;
      logic               clear_addresses;
   } rsp_type;

endpackage

// File: hw/rtl/trm_delta.sv
// Input register and per-tick delta stage of both byte counters.
module trm_delta (
   input  logic                          clock,
   input  logic                          reset,
   input  trm_pkg::delta_en_type         en,
   input  logic                          req_link_valid,
   input  logic [trm_pkg::TOTAL_W-1:0]   req_rx_total,
   input  logic [trm_pkg::TOTAL_W-1:0]   req_tx_total,
   output logic                          link_valid_d,
   output logic [trm_pkg::DELTA_W-1:0]   delta_rx_d,
   output logic [trm_pkg::DELTA_W-1:0]   delta_tx_d
);

   // Delta against the previous reading, zero while there is none, saturated.
   function automatic logic [trm_pkg::DELTA_W-1:0] make_delta(
      input logic [trm_pkg::TOTAL_W-1:0] cur,
      input logic [trm_pkg::TOTAL_W-1:0] prev
   );
      logic [trm_pkg::TOTAL_W-1:0] diff;
      diff = cur - prev;
      if (prev == '0) begin
         return '0;
      end else if (diff[trm_pkg::TOTAL_W-1:trm_pkg::DELTA_W] != '0) begin
         return trm_pkg::DELTA_MAX;
      end else begin
         return diff[trm_pkg::DELTA_W-1:0];
      end
   endfunction

   logic                        link_ff;
   logic [trm_pkg::TOTAL_W-1:0] rx_ff;
   logic [trm_pkg::TOTAL_W-1:0] tx_ff;
   logic [trm_pkg::TOTAL_W-1:0] prev_rx_ff;
   logic [trm_pkg::TOTAL_W-1:0] prev_tx_ff;
   logic [trm_pkg::TOTAL_W-1:0] prev_rx_in;
   logic [trm_pkg::TOTAL_W-1:0] prev_tx_in;
   logic                        link_d_ff;
   logic [trm_pkg::DELTA_W-1:0] delta_rx_ff;
   logic [trm_pkg::DELTA_W-1:0] delta_tx_ff;
   logic [trm_pkg::DELTA_W-1:0] delta_rx_in;
   logic [trm_pkg::DELTA_W-1:0] delta_tx_in;

   // Input register.
   always_ff @(posedge clock) begin
      if (en.load_in) begin
         link_ff <= req_link_valid;
         rx_ff   <= req_rx_total;
         tx_ff   <= req_tx_total;
      end
   end

   // An offline word stores zero deltas and forgets the previous readings.
   always_comb begin
      if (link_ff) begin
         delta_rx_in = make_delta(rx_ff, prev_rx_ff);
         delta_tx_in = make_delta(tx_ff, prev_tx_ff);
         prev_rx_in  = rx_ff;
         prev_tx_in  = tx_ff;
      end else begin
         delta_rx_in = '0;
         delta_tx_in = '0;
         prev_rx_in  = '0;
         prev_tx_in  = '0;
      end
   end

   // Previous counter readings.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_rx_ff <= '0;
         prev_tx_ff <= '0;
      end else if (en.load_delta) begin
         prev_rx_ff <= prev_rx_in;
         prev_tx_ff <= prev_tx_in;
      end
   end

   // Delta register.
   always_ff @(posedge clock) begin
      if (en.load_delta) begin
         link_d_ff   <= link_ff;
         delta_rx_ff <= delta_rx_in;
         delta_tx_ff <= delta_tx_in;
      end
   end

   assign link_valid_d = link_d_ff;
   assign delta_rx_d   = delta_rx_ff;
   assign delta_tx_d   = delta_tx_ff;

endmodule

// File: hw/rtl/trm_avg.sv
// Sliding window and truncated average of one direction's deltas.
module trm_avg (
   input  logic                        clock,
   input  logic                        reset,
   input  trm_pkg::avg_en_type         en,
   input  logic [trm_pkg::DELTA_W-1:0] delta_in,
   output logic [trm_pkg::DELTA_W-1:0] avg,
   output logic                        any_nonzero
);

   logic [trm_pkg::DELTA_W-1:0] hist_ff [trm_pkg::HIST_DEPTH];
   logic [trm_pkg::SUM_W-1:0]   sum_in;
   logic                        nz_in;
   logic [trm_pkg::SUM_W-1:0]   sum_ff;
   logic                        nz_sum_ff;
   logic [trm_pkg::PLO_W-1:0]   plo_ff;
   logic [trm_pkg::PHI_W-1:0]   phi_ff;
   logic                        nz_prod_ff;
   logic [trm_pkg::PROD_W-1:0]  prod;
   logic [trm_pkg::DELTA_W-1:0] avg_ff;
   logic                        nz_avg_ff;

   // Sum of the stored deltas and the newest one.
   always_comb begin
      sum_in = trm_pkg::SUM_W'(delta_in);
      nz_in  = (delta_in != '0);
      for (int i = 0; i < trm_pkg::HIST_DEPTH; i++) begin
         sum_in = sum_in + trm_pkg::SUM_W'(hist_ff[i]);
         nz_in  = nz_in | (hist_ff[i] != '0);
      end
   end

   // The newest delta shifts into the window.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < trm_pkg::HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (en.load_sum) begin
         for (int i = 0; i < trm_pkg::HIST_DEPTH - 1; i++) begin
            hist_ff[i] <= hist_ff[i + 1];
         end
         hist_ff[trm_pkg::HIST_DEPTH - 1] <= delta_in;
      end
   end

   // Sum register.
   always_ff @(posedge clock) begin
      if (en.load_sum) begin
         sum_ff    <= sum_in;
         nz_sum_ff <= nz_in;
      end
   end

   // Reciprocal multiplication, split into a low and a high partial product.
   always_ff @(posedge clock) begin
      if (en.load_prod) begin
         plo_ff     <= trm_pkg::PLO_W'(sum_ff[trm_pkg::LO_W-1:0])
                     * trm_pkg::PLO_W'(trm_pkg::RECIP_M);
         phi_ff     <= trm_pkg::PHI_W'(sum_ff[trm_pkg::SUM_W-1:trm_pkg::LO_W])
                     * trm_pkg::PHI_W'(trm_pkg::RECIP_M);
         nz_prod_ff <= nz_sum_ff;
      end
   end

   // Recombine the partial products; the quotient sits above the shift.
   assign prod = (trm_pkg::PROD_W'(phi_ff) << trm_pkg::LO_W) + trm_pkg::PROD_W'(plo_ff);

   always_ff @(posedge clock) begin
      if (en.load_avg) begin
         avg_ff    <= prod[trm_pkg::RECIP_SHIFT +: trm_pkg::DELTA_W];
         nz_avg_ff <= nz_prod_ff;
      end
   end

   assign avg         = avg_ff;
   assign any_nonzero = nz_avg_ff;

endmodule

// File: hw/rtl/trm_report.sv
// Display mode, idle clock, activity status and result register.
module trm_report (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic                        link_valid,
   input  logic [trm_pkg::DELTA_W-1:0] avg_rx,
   input  logic [trm_pkg::DELTA_W-1:0] avg_tx,
   input  logic                        rx_nonzero,
   input  logic [trm_pkg::DELTA_W-1:0] idle_thr,
   input  logic [trm_pkg::DELTA_W-1:0] hot_thr,
   output trm_pkg::rsp_type            rsp
);

   localparam logic [trm_pkg::MIN_W-1:0] SEC_LAST = trm_pkg::MIN_W'(trm_pkg::SECS_PER_MIN - 1);
   localparam logic [trm_pkg::MIN_W-1:0] MIN_LAST = trm_pkg::MIN_W'(trm_pkg::MINS_PER_HOUR - 1);

   logic [trm_pkg::TICKS_W-1:0] ticks_ff;
   logic [trm_pkg::TICKS_W-1:0] ticks_in;
   logic [trm_pkg::HOURS_W-1:0] hours_ff;
   logic [trm_pkg::HOURS_W-1:0] hours_in;
   logic [trm_pkg::MIN_W-1:0]   mins_ff;
   logic [trm_pkg::MIN_W-1:0]   mins_in;
   logic [trm_pkg::MIN_W-1:0]   secs_ff;
   logic [trm_pkg::MIN_W-1:0]   secs_in;
   logic [trm_pkg::MODE_W-1:0]  last_mode_ff;
   logic [trm_pkg::DELTA_W-1:0] last_rx_ff;
   logic [trm_pkg::DELTA_W-1:0] last_tx_ff;
   logic [trm_pkg::MODE_W-1:0]  mode_in;
   logic [trm_pkg::STAT_W-1:0]  status_in;
   logic [trm_pkg::DELTA_W-1:0] avg_rx_in;
   logic [trm_pkg::DELTA_W-1:0] avg_tx_in;
   logic                        active;
   logic                        hot;
   logic                        unchanged;
   trm_pkg::rsp_type            rsp_in;
   trm_pkg::rsp_type            rsp_ff;

   // Mode decision and the idle clock, kept as hours, minutes and seconds.
   always_comb begin
      active    = rx_nonzero && (avg_rx > idle_thr || avg_tx > idle_thr);
      hot       = (avg_rx > hot_thr) || (avg_tx > hot_thr);
      status_in = trm_pkg::STAT_IDLE;
      avg_rx_in = avg_rx;
      avg_tx_in = avg_tx;
      ticks_in  = '0;
      hours_in  = '0;
      mins_in   = '0;
      secs_in   = '0;
      if (!link_valid) begin
         mode_in   = trm_pkg::MODE_OFFLINE;
         avg_rx_in = '0;
         avg_tx_in = '0;
      end else if (active) begin
         mode_in = trm_pkg::MODE_RATES;
         if (hot) begin
            status_in = (avg_tx > avg_rx) ? trm_pkg::STAT_UPLOAD : trm_pkg::STAT_DOWNLOAD;
         end
      end else begin
         mode_in  = trm_pkg::MODE_IDLE;
         ticks_in = ticks_ff + 1'b1;
         // The tick counter wrapping to zero also clears the clock.
         if (ticks_ff != '1) begin
            hours_in = hours_ff;
            mins_in  = mins_ff;
            if (secs_ff != SEC_LAST) begin
               secs_in = secs_ff + 1'b1;
            end else if (mins_ff != MIN_LAST) begin
               mins_in = mins_ff + 1'b1;
            end else begin
               mins_in  = '0;
               hours_in = hours_ff + 1'b1;
            end
         end
      end

      // Same rates as the last rates display, or offline twice in a row.
      if (mode_in == trm_pkg::MODE_RATES) begin
         unchanged = (last_mode_ff == trm_pkg::MODE_RATES) && (last_rx_ff == avg_rx_in)
                     && (last_tx_ff == avg_tx_in);
      end else begin
         unchanged = (mode_in == trm_pkg::MODE_OFFLINE)
                     && (last_mode_ff == trm_pkg::MODE_OFFLINE);
      end
      if (unchanged) begin
         status_in = trm_pkg::STAT_UNCHANGED;
      end

      rsp_in.display_mode    = mode_in;
      rsp_in.avg_rx          = avg_rx_in;
      rsp_in.avg_tx          = avg_tx_in;
      rsp_in.idle_hours      = hours_in;
      rsp_in.idle_minutes    = mins_in;
      rsp_in.idle_secs_part  = secs_in;
      rsp_in.activity_status = status_in;
      rsp_in.clear_addresses = !link_valid;
   end

   // Idle clock and last display.
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff     <= '0;
         hours_ff     <= '0;
         mins_ff      <= '0;
         secs_ff      <= '0;
         last_mode_ff <= trm_pkg::MODE_NONE;
         last_rx_ff   <= '0;
         last_tx_ff   <= '0;
      end else if (load) begin
         ticks_ff     <= ticks_in;
         hours_ff     <= hours_in;
         mins_ff      <= mins_in;
         secs_ff      <= secs_in;
         last_mode_ff <= mode_in;
         last_rx_ff   <= avg_rx_in;
         last_tx_ff   <= avg_tx_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// File: hw/rtl/traffic_rate_activity_monitor_core.sv
// Top level of the traffic rate and activity monitor.
//
// Takes one poll word per clock while the input stage is ready and gives one result
// word per poll, in order. A poll passes six register stages (input, delta, window
// sum, reciprocal partial products, average, result); the edge that accepts a poll
// loads the input stage. The sustained rate is one word per cycle while the output
// is not held: the previous counters, the averaging window, the idle clock and the
// last display each update once per word. Every stage holds its word while the next
// one cannot take it, so a stalled output still lets words enter until the pipeline
// is full. The user must write thresholds through the csr port only while no poll
// is in flight; the block itself does not enforce it.
`include "assert_macros.svh"

module traffic_rate_activity_monitor_core (
   input  logic                              clock,
   input  logic                              reset,
   // Poll words.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [trm_pkg::REQ_DATA_W-1:0]    req_tdata,  // rx_total, tx_total
   input  logic                              req_tuser,  // link_valid
   // Result words.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // avg_rx, avg_tx, idle_hours, idle_minutes, idle_secs_part, activity_status,
   // clear_addresses, zero fill
   output logic [trm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [trm_pkg::MODE_W-1:0]        rsp_tuser,  // display_mode
   // Configuration writes.
   input  logic                              csr_we,
   input  logic [trm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [trm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int NUM_STAGES = 6;
   localparam int ST_IN      = 0;
   localparam int ST_DELTA   = 1;
   localparam int ST_SUM     = 2;
   localparam int ST_PROD    = 3;
   localparam int ST_AVG     = 4;
   localparam int ST_OUT     = 5;

   logic [NUM_STAGES-1:0]        valid_ff;
   logic [NUM_STAGES-1:0]        valid_in;
   logic [NUM_STAGES-1:0]        stage_rdy;
   logic [NUM_STAGES-1:0]        stage_load;
   logic [trm_pkg::DELTA_W-1:0]  idle_thr_ff;
   logic [trm_pkg::DELTA_W-1:0]  hot_thr_ff;
   trm_pkg::delta_en_type        delta_en;
   trm_pkg::avg_en_type          avg_en;
   logic                         link_d;
   logic [trm_pkg::DELTA_W-1:0]  delta_rx;
   logic [trm_pkg::DELTA_W-1:0]  delta_tx;
   logic                         link_sum_ff;
   logic                         link_prod_ff;
   logic                         link_avg_ff;
   logic [trm_pkg::DELTA_W-1:0]  avg_rx;
   logic [trm_pkg::DELTA_W-1:0]  avg_tx;
   logic                         rx_nz;
   logic                         tx_nz;
   trm_pkg::rsp_type             rsp;
   logic                         clear_ok;
   logic                         rates_clock_ok;
   logic                         clock_range_ok;
   logic                         upload_ok;
   logic                         tx_flag_ok;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_thr_ff <= '0;
         hot_thr_ff  <= trm_pkg::HOT_THR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            trm_pkg::CSR_IDLE_THR: idle_thr_ff <= csr_wdata;
            trm_pkg::CSR_HOT_THR:  hot_thr_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // A stage can take a word when it is empty or its word moves on.
   always_comb begin
      stage_rdy[ST_OUT] = !valid_ff[ST_OUT] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k + 1];
      end
      stage_load[ST_IN] = req_tvalid && stage_rdy[ST_IN];
      valid_in[ST_IN]   = stage_rdy[ST_IN] ? req_tvalid : valid_ff[ST_IN];
      for (int k = 1; k < NUM_STAGES; k++) begin
         stage_load[k] = valid_ff[k - 1] && stage_rdy[k];
         valid_in[k]   = stage_rdy[k] ? valid_ff[k - 1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_rdy[ST_IN];
   assign rsp_tvalid = valid_ff[ST_OUT];

   assign delta_en.load_in    = stage_load[ST_IN];
   assign delta_en.load_delta = stage_load[ST_DELTA];
   assign avg_en.load_sum     = stage_load[ST_SUM];
   assign avg_en.load_prod    = stage_load[ST_PROD];
   assign avg_en.load_avg     = stage_load[ST_AVG];

   // Per-tick deltas.
   trm_delta u_delta (
      .clock          (clock),
      .reset          (reset),
      .en             (delta_en),
      .req_link_valid (req_tuser),
      .req_rx_total   (req_tdata[trm_pkg::TOTAL_W-1:0]),
      .req_tx_total   (req_tdata[trm_pkg::REQ_DATA_W-1:trm_pkg::TOTAL_W]),
      .link_valid_d   (link_d),
      .delta_rx_d     (delta_rx),
      .delta_tx_d     (delta_tx)
   );

   // Link flag travels beside the averaging stages.
   always_ff @(posedge clock) begin
      if (stage_load[ST_SUM]) begin
         link_sum_ff <= link_d;
      end
      if (stage_load[ST_PROD]) begin
         link_prod_ff <= link_sum_ff;
      end
      if (stage_load[ST_AVG]) begin
         link_avg_ff <= link_prod_ff;
      end
   end

   // Receive and transmit averages.
   trm_avg u_avg_rx (
      .clock       (clock),
      .reset       (reset),
      .en          (avg_en),
      .delta_in    (delta_rx),
      .avg         (avg_rx),
      .any_nonzero (rx_nz)
   );

   trm_avg u_avg_tx (
      .clock       (clock),
      .reset       (reset),
      .en          (avg_en),
      .delta_in    (delta_tx),
      .avg         (avg_tx),
      .any_nonzero (tx_nz)
   );

   // Mode, idle clock and status.
   trm_report u_report (
      .clock          (clock),
      .reset          (reset),
      .load           (stage_load[ST_OUT]),
      .link_valid     (link_avg_ff),
      .avg_rx         (avg_rx),
      .avg_tx         (avg_tx),
      .rx_nonzero     (rx_nz),
      .idle_thr       (idle_thr_ff),
      .hot_thr        (hot_thr_ff),
      .rsp            (rsp)
   );

   // Result word packing.
   assign rsp_tuser = rsp.display_mode;
   assign rsp_tdata = {{trm_pkg::RSP_PAD_W{1'b0}}, rsp.clear_addresses, rsp.activity_status,
                       rsp.idle_secs_part, rsp.idle_minutes, rsp.idle_hours,
                       rsp.avg_tx, rsp.avg_rx};

   // Conditions that every result word and the average stage must meet.
   assign clear_ok       = rsp.clear_addresses == (rsp.display_mode == trm_pkg::MODE_OFFLINE);
   assign rates_clock_ok = (rsp.display_mode != trm_pkg::MODE_RATES)
                           || ({rsp.idle_hours, rsp.idle_minutes, rsp.idle_secs_part} == '0);
   assign clock_range_ok = (rsp.idle_minutes < trm_pkg::MIN_W'(trm_pkg::MINS_PER_HOUR))
                           && (rsp.idle_secs_part < trm_pkg::MIN_W'(trm_pkg::SECS_PER_MIN));
   assign upload_ok      = (rsp.activity_status != trm_pkg::STAT_UPLOAD)
                           || ((rsp.display_mode == trm_pkg::MODE_RATES)
                               && (rsp.avg_tx > rsp.avg_rx));
   assign tx_flag_ok     = !valid_ff[ST_AVG] || (avg_tx == '0) || tx_nz;

   // Checks on the result words and the average stage.
   `ASSERT_CLK(a_clear_offline, clock, reset, rsp_tvalid |-> clear_ok, "clear flag disagrees with mode")
   `ASSERT_CLK(a_rates_no_clock, clock, reset, rsp_tvalid |-> rates_clock_ok, "idle clock in rates")
   `ASSERT_CLK(a_clock_range, clock, reset, rsp_tvalid |-> clock_range_ok, "idle clock out of range")
   `ASSERT_CLK(a_upload_rates, clock, reset, rsp_tvalid |-> upload_ok, "upload status without rates")
   `ASSERT_CLK(a_tx_window_flag, clock, reset, tx_flag_ok, "transmit average from a silent window")

endmodule
